// ===== design/hlfp_pkg.sv =====
// Shared types and constants of the header and length frame parser.
package hlfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 7;
	localparam int unsigned TOTAL_W = 9;

	localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'h5A;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hA5;
	localparam logic [TOTAL_W-1:0] HEADER_BYTES = 9'd3;
	localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

	typedef enum logic {
		ST_RECV,
		ST_EMIT
	} state_t;

endpackage

// ===== design/header_length_frame_parser_top.sv =====
// Top level of the header and length frame parser with its frame buffer.
// Usage: received bytes enter on the s_ channel, one item per byte. The block
// hunts for the sync header 0x5A 0xA5, takes the next byte as payload length L
// and stores the frame of 3 + L bytes in its buffer RAM. Frames longer than
// MAX_FRAME or the limit written on the cfg_ port are dropped silently.
// A complete frame leaves on the m_ channel as 3 + L items, header first,
// each carrying the frame length, with tlast on the final byte.
// While receiving, one byte is taken every cycle. Emission then reads the
// buffer through its single registered read port at one byte per cycle while
// the receiver keeps up, and the input stays blocked until the final byte of
// the frame has been loaded into the output register.
// s_tready is low during emission. A stalled receiver holds the output
// register, and the buffer read is held until the register frees up.
// Reset returns to hunting with the limit at 64; the buffer is not cleared,
// since only entries written for the current frame are ever read.
module header_length_frame_parser_top #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,     // rx_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,     // frame_byte, frame_length, zero pad
	output logic                             m_tlast,     // last_byte
	input  logic                             cfg_wr_en,
	input  logic [hlfp_pkg::LEN_W-1:0]       cfg_wr_data  // max_frame_bytes
);

	localparam int unsigned AW = $clog2(MAX_FRAME);
	localparam int unsigned HW = $clog2(MAX_FRAME + 1);

	hlfp_pkg::state_t state_q, state_d;

	logic [hlfp_pkg::LEN_W-1:0]   limit_q;
	logic [HW-1:0]                held_q, held_d, held_inc;
	logic [hlfp_pkg::TOTAL_W-1:0] expected_q, expected_d, total;
	logic [hlfp_pkg::LEN_W-1:0]   len_q;
	logic [HW-1:0]                rd_idx_q, out_idx_q;
	logic                         pend_q;
	logic                         frame_done;

	logic                         in_acc, load, issue, out_last;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [hlfp_pkg::BYTE_W-1:0]  rd_data;

	logic                         m_valid_q;
	logic [hlfp_pkg::BYTE_W-1:0]  m_byte_q;
	logic [hlfp_pkg::LEN_W-1:0]   m_len_q;
	logic                         m_last_q;

	assign in_acc = s_tvalid && s_tready;
	assign held_inc = held_q + 1'b1;
	assign total = hlfp_pkg::HEADER_BYTES + hlfp_pkg::TOTAL_W'(s_tdata);
	assign out_last = (hlfp_pkg::LEN_W'(out_idx_q) + 1'b1) == len_q;

	// Receive path: header hunt, length check and buffer writes.
	always_comb begin
		held_d = held_q;
		expected_d = expected_q;
		wr_en = 1'b0;
		wr_addr = held_q[AW-1:0];
		frame_done = 1'b0;
		if (held_q == '0) begin
			if (s_tdata == hlfp_pkg::SYNC_FIRST) begin
				wr_en = 1'b1;
				held_d = held_inc;
			end
		end else if (held_q == HW'(1)) begin
			if (s_tdata == hlfp_pkg::SYNC_SECOND) begin
				wr_en = 1'b1;
				held_d = held_inc;
			end else if (s_tdata == hlfp_pkg::SYNC_FIRST) begin
				wr_en = 1'b1;
				wr_addr = '0;
			end else begin
				held_d = '0;
			end
		end else begin
			wr_en = 1'b1;
			held_d = held_inc;
			if (held_q == HW'(2)) begin
				expected_d = total;
				if (total > hlfp_pkg::TOTAL_W'(MAX_FRAME) ||
				    total > hlfp_pkg::TOTAL_W'(limit_q)) begin
					held_d = '0;
					expected_d = '0;
				end else if (total == hlfp_pkg::HEADER_BYTES) begin
					frame_done = 1'b1;
				end
			end else if (hlfp_pkg::TOTAL_W'(held_inc) >= expected_q) begin
				frame_done = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hlfp_pkg::ST_RECV: begin
				if (in_acc && frame_done) begin
					state_d = hlfp_pkg::ST_EMIT;
				end
			end
			hlfp_pkg::ST_EMIT: begin
				if (load && out_last) begin
					state_d = hlfp_pkg::ST_RECV;
				end
			end
			default: state_d = hlfp_pkg::ST_RECV;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		load = 1'b0;
		issue = 1'b0;
		case (state_q)
			hlfp_pkg::ST_RECV: begin
				s_tready = 1'b1;
			end
			hlfp_pkg::ST_EMIT: begin
				load = pend_q && (!m_valid_q || m_tready);
				issue = (hlfp_pkg::LEN_W'(rd_idx_q) < len_q) && (!pend_q || load);
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	hlfp_ram #(
		.WIDTH (hlfp_pkg::BYTE_W),
		.DEPTH (MAX_FRAME)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc && wr_en),
		.wr_addr (wr_addr),
		.wr_data (s_tdata),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hlfp_pkg::ST_RECV;
			limit_q <= hlfp_pkg::LIMIT_RESET;
			held_q <= '0;
			expected_q <= '0;
			len_q <= '0;
			rd_idx_q <= '0;
			out_idx_q <= '0;
			pend_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (in_acc) begin
				held_q <= frame_done ? '0 : held_d;
				expected_q <= frame_done ? '0 : expected_d;
				if (frame_done) begin
					len_q <= hlfp_pkg::LEN_W'(held_inc);
					rd_idx_q <= '0;
					out_idx_q <= '0;
					pend_q <= 1'b0;
				end
			end
			if (state_q == hlfp_pkg::ST_EMIT) begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
					pend_q <= 1'b1;
				end else if (load) begin
					pend_q <= 1'b0;
				end
				if (load) begin
					out_idx_q <= out_idx_q + 1'b1;
				end
			end
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_byte_q <= rd_data;
			m_len_q <= len_q;
			m_last_q <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, m_len_q, m_byte_q};
	assign m_tlast = m_last_q;

	a_back_to_recv: assert property (@(posedge clk) disable iff (!arst_n)
		(load && out_last) |=> (state_q == hlfp_pkg::ST_RECV))
		else $error("Parser did not return to receiving after the last frame byte.");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q < HW'(MAX_FRAME)))
		else $error("Stored byte count reached the buffer depth.");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlfp_pkg::ST_EMIT) |-> (hlfp_pkg::LEN_W'(rd_idx_q) <= len_q))
		else $error("Buffer read index ran past the frame length.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_valid_q || m_tready))
		else $error("Output register overwritten while holding an item.");

endmodule

// ===== design/hlfp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module hlfp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the header and length frame parser.
module testbench;

	localparam int MAX_FRAME = 64;
	localparam int AW = $clog2(MAX_FRAME);
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_BURSTY
	} rx_mode_t;

	typedef struct packed {
		logic [hlfp_pkg::BYTE_W-1:0] data;
		logic [hlfp_pkg::LEN_W-1:0] len;
		logic last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic [hlfp_pkg::LEN_W-1:0] cfg_wr_data = '0;

	logic [7:0] pending_rx[$];
	frame_byte_t expected_frame_q[$];

	logic [hlfp_pkg::LEN_W-1:0] rx_held;
	logic [hlfp_pkg::TOTAL_W-1:0] rx_total;
	logic [hlfp_pkg::BYTE_W-1:0] frame_buf[MAX_FRAME];
	logic [hlfp_pkg::LEN_W-1:0] frame_limit;

	int error_count = 0;
	int accepted_count = 0;
	int checked_count = 0;
	int frame_count = 0;
	int queued_count = 0;
	int cycle_count = 0;
	int burst_left;
	int gap_left;
	int stall_left;
	rx_mode_t rx_mode = RX_ALWAYS;

	header_length_frame_parser_top #(
		.MAX_FRAME(MAX_FRAME)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void note_error(string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void store_byte(logic [hlfp_pkg::BYTE_W-1:0] b);
		if (rx_held < MAX_FRAME) begin
			frame_buf[rx_held[AW-1:0]] = b;
			rx_held++;
		end else begin
			rx_held = '0;
			rx_total = '0;
		end
	endfunction

	function automatic void emit_frame();
		int n;
		frame_byte_t fb;
		n = (rx_held > MAX_FRAME) ? MAX_FRAME : int'(rx_held);
		for (int k = 0; k < n; k++) begin
			fb.data = frame_buf[k[AW-1:0]];
			fb.len = hlfp_pkg::LEN_W'(n);
			fb.last = (k == n - 1);
			expected_frame_q.push_back(fb);
		end
		frame_count++;
		rx_held = '0;
		rx_total = '0;
	endfunction

	function automatic void predict_rx(logic [hlfp_pkg::BYTE_W-1:0] b);
		if (rx_held == 0) begin
			if (b == hlfp_pkg::SYNC_FIRST) begin
				store_byte(b);
			end
		end else if (rx_held == 1) begin
			if (b == hlfp_pkg::SYNC_SECOND) begin
				store_byte(b);
			end else if (b == hlfp_pkg::SYNC_FIRST) begin
				frame_buf[0] = b;
			end else begin
				rx_held = '0;
			end
		end else begin
			store_byte(b);
			if (rx_held == hlfp_pkg::HEADER_BYTES) begin
				rx_total = hlfp_pkg::HEADER_BYTES + b;
				if (rx_total > MAX_FRAME || rx_total > frame_limit) begin
					rx_held = '0;
					rx_total = '0;
				end else if (rx_total == hlfp_pkg::HEADER_BYTES) begin
					emit_frame();
				end
			end else if (rx_held != 0 && rx_held >= rx_total) begin
				emit_frame();
			end
		end
	endfunction

	// Byte driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_rx.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_rx.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 32);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
						($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) :
						$urandom_range(1, 4);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_COIN: m_tready <= 1'($urandom_range(0, 1));
				default: begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 11) == 0) begin
						stall_left <= $urandom_range(1, 24);
					end
				end
			endcase
		end
	end

	// Monitor: checks emitted frame bytes and predicts from accepted bytes.
	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		if (!arst_n) begin
			rx_held = '0;
			rx_total = '0;
			frame_limit = hlfp_pkg::LIMIT_RESET;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_frame_q.size() == 0) begin
					note_error($sformatf("Unexpected frame byte: data %02h len %0d last %0b",
						m_tdata[7:0], m_tdata[14:8], m_tlast));
				end else begin
					want = expected_frame_q.pop_front();
					checked_count++;
					if (m_tdata[7:0] != want.data || m_tdata[14:8] != want.len ||
						m_tlast != want.last) begin
						note_error($sformatf(
							"Mismatch: expected data %02h len %0d last %0b, got %02h %0d %0b",
							want.data, want.len, want.last,
							m_tdata[7:0], m_tdata[14:8], m_tlast));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_rx(s_tdata);
				accepted_count++;
			end
			if (cfg_wr_en) begin
				frame_limit = cfg_wr_data;
			end
		end
	end

	task automatic queue_byte(logic [7:0] b);
		pending_rx.push_back(b);
		queued_count++;
	endtask

	task automatic queue_frame(int len, int eff_limit);
		int payload;
		queue_byte(hlfp_pkg::SYNC_FIRST);
		queue_byte(hlfp_pkg::SYNC_SECOND);
		queue_byte(8'(len));
		payload = (len + 3 <= eff_limit) ? len : $urandom_range(0, 3);
		repeat (payload) queue_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic int pick_len(int eff_limit);
		case ($urandom_range(0, 19))
			0: return MAX_FRAME - 3;
			1: return $urandom_range(MAX_FRAME - 2, 255);
			2: return (eff_limit >= 3) ? eff_limit - 3 : 0;
			3: return (eff_limit >= 2) ? eff_limit - 2 : 1;
			default: return $urandom_range(0, 8);
		endcase
	endfunction

	task automatic wait_idle();
		while (pending_rx.size() != 0 || s_tvalid || expected_frame_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [hlfp_pkg::LEN_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(int count, int limit_value);
		int start;
		int eff;
		start = queued_count;
		eff = (limit_value > MAX_FRAME) ? MAX_FRAME : limit_value;
		while (queued_count - start < count) begin
			case ($urandom_range(0, 9))
				0: queue_byte(8'($urandom_range(0, 255)));
				1: begin
					queue_byte(hlfp_pkg::SYNC_FIRST);
					queue_byte(8'($urandom_range(0, 255)));
				end
				2: begin
					repeat ($urandom_range(1, 3)) queue_byte(hlfp_pkg::SYNC_FIRST);
					queue_frame(pick_len(eff), eff);
				end
				3: begin
					queue_byte(hlfp_pkg::SYNC_FIRST);
					queue_byte(hlfp_pkg::SYNC_SECOND);
				end
				default: queue_frame(pick_len(eff), eff);
			endcase
		end
	endtask

	initial begin
		int limits[8];
		limits = '{3, 127, 0, 2, 64, 4, 33, 64};
		limits[5] = $urandom_range(4, 63);
		limits[6] = $urandom_range(3, 64);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Noise while hunting, a zero-length frame, a restarted header,
		// a broken header, an oversize length and sync bytes as payload.
		queue_byte(hlfp_pkg::SYNC_SECOND);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_frame(0, MAX_FRAME);
		queue_byte(hlfp_pkg::SYNC_FIRST);
		queue_byte(hlfp_pkg::SYNC_FIRST);
		queue_byte(hlfp_pkg::SYNC_SECOND);
		queue_byte(8'h01);
		queue_byte(8'hFF);
		queue_byte(hlfp_pkg::SYNC_FIRST);
		queue_byte(8'h00);
		queue_frame(255, MAX_FRAME);
		queue_byte(hlfp_pkg::SYNC_FIRST);
		queue_byte(hlfp_pkg::SYNC_SECOND);
		queue_byte(8'h02);
		queue_byte(hlfp_pkg::SYNC_FIRST);
		queue_byte(hlfp_pkg::SYNC_SECOND);
		wait_idle();

		foreach (limits[i]) begin
			write_limit(hlfp_pkg::LEN_W'(limits[i]));
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			run_random(56, limits[i]);
			wait_idle();
		end

		$display("Accepted %0d received bytes under %0d limit settings.",
			accepted_count, $size(limits) + 1);
		$display("Checked %0d frame bytes in %0d frames, %0d mismatches.",
			checked_count, frame_count, error_count);
		if (error_count == 0 && expected_frame_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
